// ===== rtl/core/esv_pkg.sv =====
// Shared types, widths and constants of the ellipse/sprite vertex generator.
package esv_pkg;

    localparam int SIZE_W    = 16;
    localparam int PC_W      = 11;
    localparam int DEN_W     = PC_W + 1;
    localparam int FRAC_W    = 16;
    localparam int XY_W      = 33;
    localparam int Z_W       = 32;
    localparam int T_W       = 32;
    localparam int PROD_W    = SIZE_W + T_W;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int ATAN_LEN  = 24;

    localparam logic [FRAC_W-1:0] QUARTER_TURN = 16'h4000;
    localparam logic [FRAC_W-1:0] EIGHTH_TURN  = 16'h2000;
    localparam logic signed [XY_W-1:0] GAIN_Q30 = 33'sd652032874;
    localparam logic signed [XY_W:0]   ONE_Q30  = 34'sd1073741824;
    localparam logic [SIZE_W-1:0]      SAT_MAX  = 16'hFFFF;

    // arctangent of 2^-i in 2^-32 turn units
    localparam logic signed [Z_W-1:0] ATAN_TURNS [0:ATAN_LEN-1] = '{
        32'sh20000000, 32'sh12E4051E, 32'sh09FB385B, 32'sh051111D4,
        32'sh028B0D43, 32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55,
        32'sh0028BE53, 32'sh00145F2F, 32'sh000A2F98, 32'sh000517CC,
        32'sh00028BE6, 32'sh000145F3, 32'sh0000A2FA, 32'sh0000517D,
        32'sh000028BE, 32'sh0000145F, 32'sh00000A30, 32'sh00000518,
        32'sh0000028C, 32'sh00000146, 32'sh000000A3, 32'sh00000051
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SHAPE_MODE  = 2'd0,
        REG_SIZE_X      = 2'd1,
        REG_SIZE_Y      = 2'd2,
        REG_POINT_COUNT = 2'd3
    } t_reg_idx;

    // control that travels with each beat
    typedef struct packed {
        logic       vld;
        logic       corner_ok;
        logic [1:0] corner;
    } t_tag;

endpackage

// ===== rtl/core/esv_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, low FRAC_W bits kept.
module esv_div import esv_pkg::*; #(
    parameter int NUM_W = 27
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_tag              i_tag,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    output t_tag              o_tag,
    output logic [FRAC_W-1:0] o_quo
);

    t_tag              s_tag [0:NUM_W];
    logic [NUM_W-1:0]  s_num [0:NUM_W];
    logic [DEN_W-1:0]  s_rem [0:NUM_W];
    logic [FRAC_W-1:0] s_quo [0:NUM_W];

    assign s_tag[0] = i_tag;
    assign s_num[0] = i_num;
    assign s_rem[0] = '0;
    assign s_quo[0] = '0;

    for (genvar s = 0; s < NUM_W; s++) begin : g_stage
        logic [DEN_W:0] trial;
        logic [DEN_W:0] diff;
        logic           qbit;

        always_comb begin
            trial = {s_rem[s], s_num[s][NUM_W-1]};
            diff  = trial - {1'b0, i_den};
            qbit  = (trial >= {1'b0, i_den});
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                s_tag[s+1] <= '0;
            end else begin
                s_tag[s+1] <= s_tag[s];
            end
        end

        always_ff @(posedge i_clk) begin
            s_num[s+1] <= s_num[s] << 1;
            s_rem[s+1] <= qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            s_quo[s+1] <= {s_quo[s][FRAC_W-2:0], qbit};
        end
    end

    assign o_tag = s_tag[NUM_W];
    assign o_quo = s_quo[NUM_W];

endmodule

// ===== rtl/core/esv_cordic.sv =====
// Quadrant split of the turn angle and pipelined rotation-mode CORDIC.
module esv_cordic import esv_pkg::*; #(
    parameter int STAGES = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_tag                   i_tag,
    input  logic [FRAC_W-1:0]      i_frac,
    output t_tag                   o_tag,
    output logic signed [XY_W-1:0] o_x,
    output logic signed [XY_W-1:0] o_y,
    output logic [1:0]             o_quad
);

    logic [FRAC_W-1:0] ang;
    logic [FRAC_W-1:0] ang_rnd;
    logic [FRAC_W-1:0] resid;

    t_tag                   s_tag  [0:STAGES];
    logic signed [XY_W-1:0] s_x    [0:STAGES];
    logic signed [XY_W-1:0] s_y    [0:STAGES];
    logic signed [Z_W-1:0]  s_z    [0:STAGES];
    logic [1:0]             s_quad [0:STAGES];

    // rotate by minus a quarter turn, then split off the nearest quarter
    always_comb begin
        ang     = i_frac - QUARTER_TURN;
        ang_rnd = ang + EIGHTH_TURN;
        resid   = ang - {ang_rnd[FRAC_W-1:FRAC_W-2], {(FRAC_W-2){1'b0}}};
    end

    assign s_tag[0]  = i_tag;
    assign s_x[0]    = GAIN_Q30;
    assign s_y[0]    = '0;
    assign s_z[0]    = signed'({resid, {(Z_W-FRAC_W){1'b0}}});
    assign s_quad[0] = ang_rnd[FRAC_W-1:FRAC_W-2];

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        localparam logic signed [Z_W-1:0] ATAN_I = ATAN_TURNS[i];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                s_tag[i+1] <= '0;
            end else begin
                s_tag[i+1] <= s_tag[i];
            end
        end

        always_ff @(posedge i_clk) begin
            s_quad[i+1] <= s_quad[i];
            if (!s_z[i][Z_W-1]) begin
                s_x[i+1] <= s_x[i] - (s_y[i] >>> i);
                s_y[i+1] <= s_y[i] + (s_x[i] >>> i);
                s_z[i+1] <= s_z[i] - ATAN_I;
            end else begin
                s_x[i+1] <= s_x[i] + (s_y[i] >>> i);
                s_y[i+1] <= s_y[i] - (s_x[i] >>> i);
                s_z[i+1] <= s_z[i] + ATAN_I;
            end
        end
    end

    assign o_tag  = s_tag[STAGES];
    assign o_x    = s_x[STAGES];
    assign o_y    = s_y[STAGES];
    assign o_quad = s_quad[STAGES];

endmodule

// ===== rtl/core/esv_scale.sv =====
// Quadrant rotation, radius scaling with rounding and saturation, sprite corner select.
module esv_scale import esv_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_tag                   i_tag,
    input  logic signed [XY_W-1:0] i_x,
    input  logic signed [XY_W-1:0] i_y,
    input  logic [1:0]             i_quad,
    input  logic                   i_shape_mode,
    input  logic [SIZE_W-1:0]      i_size_x,
    input  logic [SIZE_W-1:0]      i_size_y,
    output logic                   o_valid,
    output logic [SIZE_W-1:0]      o_point_x,
    output logic [SIZE_W-1:0]      o_point_y
);

    logic signed [XY_W-1:0] cs;
    logic signed [XY_W-1:0] sn;
    logic signed [XY_W:0]   t_x;
    logic signed [XY_W:0]   t_y;

    t_tag              r_tag_a;
    t_tag              r_tag_b;
    logic [T_W-1:0]    r_t_x;
    logic [T_W-1:0]    r_t_y;
    logic [PROD_W-1:0] r_prod_x;
    logic [PROD_W-1:0] r_prod_y;
    logic              r_valid;
    logic [SIZE_W-1:0] r_point_x;
    logic [SIZE_W-1:0] r_point_y;

    logic [PROD_W:0]   n_sum_x;
    logic [PROD_W:0]   n_sum_y;
    logic [SIZE_W+1:0] n_sh_x;
    logic [SIZE_W+1:0] n_sh_y;
    logic [SIZE_W-1:0] n_point_x;
    logic [SIZE_W-1:0] n_point_y;

    always_comb begin
        unique case (i_quad)
            2'd0: begin
                cs = i_x;
                sn = i_y;
            end
            2'd1: begin
                cs = -i_y;
                sn = i_x;
            end
            2'd2: begin
                cs = -i_x;
                sn = -i_y;
            end
            default: begin
                cs = i_y;
                sn = -i_x;
            end
        endcase
        t_x = ONE_Q30 + {cs[XY_W-1], cs};
        t_y = ONE_Q30 + {sn[XY_W-1], sn};
    end

    always_comb begin
        n_sum_x = {1'b0, r_prod_x} + (PROD_W+1)'(ONE_Q30);
        n_sum_y = {1'b0, r_prod_y} + (PROD_W+1)'(ONE_Q30);
        n_sh_x  = n_sum_x[PROD_W:31];
        n_sh_y  = n_sum_y[PROD_W:31];
        n_point_x = (n_sh_x > {2'b00, SAT_MAX}) ? SAT_MAX : n_sh_x[SIZE_W-1:0];
        n_point_y = (n_sh_y > {2'b00, SAT_MAX}) ? SAT_MAX : n_sh_y[SIZE_W-1:0];
        if (i_shape_mode) begin
            n_point_x = '0;
            n_point_y = '0;
            if (r_tag_b.corner_ok && (r_tag_b.corner == 2'd1 || r_tag_b.corner == 2'd2)) begin
                n_point_x = i_size_x;
            end
            if (r_tag_b.corner_ok && (r_tag_b.corner == 2'd2 || r_tag_b.corner == 2'd3)) begin
                n_point_y = i_size_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_a <= '0;
            r_tag_b <= '0;
            r_valid <= 1'b0;
        end else begin
            r_tag_a <= i_tag;
            r_tag_b <= r_tag_a;
            r_valid <= r_tag_b.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        // clamp negative radius factor to zero
        r_t_x     <= t_x[XY_W] ? '0 : t_x[T_W-1:0];
        r_t_y     <= t_y[XY_W] ? '0 : t_y[T_W-1:0];
        r_prod_x  <= {{T_W{1'b0}}, i_size_x} * {{SIZE_W{1'b0}}, r_t_x};
        r_prod_y  <= {{T_W{1'b0}}, i_size_y} * {{SIZE_W{1'b0}}, r_t_y};
        r_point_x <= n_point_x;
        r_point_y <= n_point_y;
    end

    assign o_valid   = r_valid;
    assign o_point_x = r_point_x;
    assign o_point_y = r_point_y;

endmodule

// ===== rtl/core/ellipse_sprite_vertex_generator.sv =====
// From start to o_valid: input register, divider stages, CORDIC stages, scale registers.
// Throughput: one vertex per cycle; o_busy stays low, the pipeline takes a beat every cycle.
// Latency grows with the one-bit-per-stage divider (INDEX_BITS + 17 stages) and the CORDIC stages.
// The receiver cannot stall: each result shows for one cycle with o_valid high.
// Synchronous active-low reset clears all valid bits and loads the register reset values.
module ellipse_sprite_vertex_generator import esv_pkg::*; #(
    parameter int INDEX_BITS    = 10,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  logic [INDEX_BITS-1:0] i_vertex_index,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_data,
    output logic                  o_valid,
    output logic [SIZE_W-1:0]     o_point_x,
    output logic [SIZE_W-1:0]     o_point_y
);

    localparam int NUM_W   = INDEX_BITS + 17;
    localparam int LATENCY = INDEX_BITS + CORDIC_STAGES + 21;

    logic              r_shape_mode;
    logic [SIZE_W-1:0] r_size_x;
    logic [SIZE_W-1:0] r_size_y;
    logic [PC_W-1:0]   r_point_count;

    t_tag                  r_in_tag;
    logic [INDEX_BITS-1:0] r_in_idx;

    logic [PC_W-1:0]        pc_eff;
    logic [DEN_W-1:0]       den;
    logic [NUM_W-1:0]       num;
    t_tag                   div_tag;
    logic [FRAC_W-1:0]      div_quo;
    t_tag                   cor_tag;
    logic signed [XY_W-1:0] cor_x;
    logic signed [XY_W-1:0] cor_y;
    logic [1:0]             cor_quad;

    assign o_busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shape_mode  <= 1'b0;
            r_size_x      <= '0;
            r_size_y      <= '0;
            r_point_count <= PC_W'(4);
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_SHAPE_MODE:  r_shape_mode  <= i_cfg_data[0];
                REG_SIZE_X:      r_size_x      <= i_cfg_data[SIZE_W-1:0];
                REG_SIZE_Y:      r_size_y      <= i_cfg_data[SIZE_W-1:0];
                REG_POINT_COUNT: r_point_count <= i_cfg_data[PC_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_tag <= '0;
        end else begin
            r_in_tag.vld       <= i_start && !o_busy;
            r_in_tag.corner_ok <= ((i_vertex_index >> 2) == '0);
            r_in_tag.corner    <= i_vertex_index[1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_idx <= i_vertex_index;
    end

    // frac = (idx * 2^17 + pc) / (2 * pc); zero points count as one
    always_comb begin
        pc_eff = (r_point_count == '0) ? PC_W'(1) : r_point_count;
        den    = {pc_eff, 1'b0};
        num    = {r_in_idx, {(17-PC_W){1'b0}}, pc_eff};
    end

    esv_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (r_in_tag),
        .i_num   (num),
        .i_den   (den),
        .o_tag   (div_tag),
        .o_quo   (div_quo)
    );

    esv_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (div_tag),
        .i_frac  (div_quo),
        .o_tag   (cor_tag),
        .o_x     (cor_x),
        .o_y     (cor_y),
        .o_quad  (cor_quad)
    );

    esv_scale u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tag        (cor_tag),
        .i_x          (cor_x),
        .i_y          (cor_y),
        .i_quad       (cor_quad),
        .i_shape_mode (r_shape_mode),
        .i_size_x     (r_size_x),
        .i_size_y     (r_size_y),
        .o_valid      (o_valid),
        .o_point_x    (o_point_x),
        .o_point_y    (o_point_y)
    );

    a_valid_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start, LATENCY))
        else $error("result strobe without a matching start");

    a_sprite_x_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_shape_mode) |-> (o_point_x == '0 || o_point_x == r_size_x))
        else $error("sprite x is neither origin nor width");

    a_zero_size_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !r_shape_mode && r_size_x == '0) |-> (o_point_x == '0))
        else $error("ellipse x nonzero with zero width");

endmodule
